FILE: src/weighted_3x3_denoise_filter_assert.svh
// Assertion macros for the denoise filter checker.
// No dependencies; included by the checker file.
`ifndef WEIGHTED_3X3_DENOISE_FILTER_ASSERT_SVH
`define WEIGHTED_3X3_DENOISE_FILTER_ASSERT_SVH

// same-cycle implication
`define WDN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WDN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/wdn_pkg.sv
// Shared constants and the divider chain beat type for the denoise filter.
// No dependencies.
package wdn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W  = 11;                 // frame_width / frame_height fields
  localparam int STR_W  = 9;                  // strength_q8 field
  localparam int CH_W   = 8;
  localparam int PIX_W  = 4 * CH_W;
  localparam int NCH    = 3;                  // filtered channels
  localparam int QUO_W  = 8;
  localparam int ACC_W  = 20;                 // 9 * 255 * 256 fits
  localparam int WS_W   = 12;                 // 9 * 256 fits

  localparam int RING   = 2 * MAX_WIDTH + 3;
  localparam int RING_W = $clog2(RING);
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int K_W    = $clog2(CNT_W);

  localparam logic [STR_W-1:0] W_CENTER = STR_W'(256);

  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_STRENGTH = 2'd2;

  typedef struct packed {
    logic                            valid;
    logic [NCH-1:0][ACC_W-1:0]       rem;
    logic [NCH-1:0][QUO_W-1:0]       quo;
    logic [ACC_W-1:0]                dvs;
    logic [CH_W-1:0]                 alpha;
    logic                            fend;
  } div_t;

endpackage

FILE: src/wdn_div_cell.sv
// One restoring division step for three channels, registered.
// Depends on wdn_pkg.
module wdn_div_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  wdn_pkg::div_t d_i,
  output wdn_pkg::div_t d_o
);
  import wdn_pkg::*;

  div_t d_d, pay_q;
  logic valid_q;

  always_comb begin
    d_d = d_i;
    for (int c = 0; c < NCH; c++) begin
      if (d_i.rem[c] >= d_i.dvs) begin
        d_d.rem[c] = d_i.rem[c] - d_i.dvs;
        d_d.quo[c] = {d_i.quo[c][QUO_W-2:0], 1'b1};
      end else begin
        d_d.quo[c] = {d_i.quo[c][QUO_W-2:0], 1'b0};
      end
    end
    // divisor halves on its way to the next cell
    d_d.dvs = d_i.dvs >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= d_d;
  end

  always_comb begin
    d_o       = pay_q;
    d_o.valid = valid_q;
  end

endmodule

FILE: src/weighted_3x3_denoise_filter.sv
// Center-weighted 3x3 mean filter over an RGBA raster stream.
// Takes one beat at a time. Beats that emit a result are paced by the bit-serial
// position/ring-offset loop (CNT_W steps) and 9 ring reads, and wait while the divider
// chain or the output register still holds a result. Reset clears the counters and state
// and loads the default configuration; the datapath and pixel ring have no reset.
// Depends on wdn_pkg and wdn_div_cell.
module weighted_3x3_denoise_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [wdn_pkg::CH_W-1:0]   red_in_i,
  input  logic [wdn_pkg::CH_W-1:0]   green_in_i,
  input  logic [wdn_pkg::CH_W-1:0]   blue_in_i,
  input  logic [wdn_pkg::CH_W-1:0]   alpha_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [wdn_pkg::CH_W-1:0]   red_out_o,
  output logic [wdn_pkg::CH_W-1:0]   green_out_o,
  output logic [wdn_pkg::CH_W-1:0]   blue_out_o,
  output logic [wdn_pkg::CH_W-1:0]   alpha_out_o,
  output logic                       frame_end_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [wdn_pkg::DIM_W-1:0]  cfg_data_i
);
  import wdn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRE  = 4'd1;
  localparam logic [3:0] S_WAIT = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_BASE = 4'd5;
  localparam logic [3:0] S_NBR  = 4'd6;
  localparam logic [3:0] S_LAST = 4'd7;
  localparam logic [3:0] S_PUSH = 4'd8;

  localparam int RK_W = CNT_W + RING_W;

  logic [DIM_W-1:0] cfg_w_q, cfg_h_q;
  logic [STR_W-1:0] cfg_s_q;
  logic [DIM_W-1:0] w, h;
  logic [STR_W-1:0] nw;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] total_q, incount_q, outcnt_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [RING_W-1:0] wp_q;
  logic [PIX_W-1:0] pix_q;
  logic             act_q;

  logic [PIX_W-1:0] ring_mem [RING];
  logic [PIX_W-1:0] rdata_q;

  logic [CNT_W-1:0] pdiv_q, dquo_q, mrem_q;
  logic [DIM_W-1:0] drem_q;
  logic [RK_W-1:0]  rk_q;
  logic             dneg_q;
  logic [K_W-1:0]   k_q;

  logic [RING_W-1:0] base_q;
  logic [1:0]        dy_q, dx_q;
  logic              rd_ok_q, rd_ctr_q;
  logic [STR_W-1:0]  wt_q;
  logic [NCH-1:0][ACC_W-1:0] acc_q;
  logic [WS_W-1:0]   ws_q;
  logic [CH_W-1:0]   center_q;

  logic              pix_ok, emit_go, push, fend;
  logic [CNT_W:0]    dval;
  logic [DIM_W:0]    rem_sh;
  logic [RING_W:0]   dm, base_sum;
  logic [CNT_W:0]    ey;
  logic [DIM_W:0]    ex;
  logic              in_frame;
  logic [DIM_W+1:0]  offp;
  logic [RING_W+2:0] addr_sum;
  logic [RING_W-1:0] addr;
  logic [DIM_W:0]    col_inc;

  div_t chain [QUO_W+1];
  logic chain_busy;
  logic out_valid_q;
  logic [NCH-1:0][CH_W-1:0] out_rgb_q;
  logic [CH_W-1:0] out_alpha_q;
  logic out_fend_q;

  // clamped registers
  always_comb begin
    if (cfg_w_q == '0) begin
      w = DIM_W'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = cfg_w_q;
    end
    if (cfg_h_q == '0) begin
      h = DIM_W'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = cfg_h_q;
    end
    nw = (cfg_s_q > W_CENTER) ? '0 : W_CENTER - cfg_s_q;
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= DIM_W'(640);
      cfg_h_q <= DIM_W'(480);
      cfg_s_q <= STR_W'(77);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:    cfg_w_q <= cfg_data_i;
        CFG_HEIGHT:   cfg_h_q <= cfg_data_i;
        CFG_STRENGTH: cfg_s_q <= cfg_data_i[STR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      incount_q <= '0;
    end else begin
      total_q   <= CNT_W'(w * h);
      incount_q <= CNT_W'(row_q * w) + CNT_W'(col_q);
    end
  end

  // sequencer decisions
  assign pix_ok  = (incount_q < total_q);
  assign emit_go = ((state_q == S_PRE) && act_q && !pix_ok && (outcnt_q < total_q)) ||
                   ((state_q == S_DEC) && (incount_q >= CNT_W'(w) + CNT_W'(2)) &&
                    (outcnt_q < total_q));
  assign dval    = {1'b0, incount_q} - (CNT_W+1)'(1) - {1'b0, outcnt_q};
  assign rem_sh  = {drem_q, pdiv_q[CNT_W-1]};
  assign push    = (state_q == S_PUSH) && !out_valid_q && !chain_busy;
  assign fend    = ((outcnt_q + CNT_W'(1)) >= total_q);
  assign col_inc = {1'b0, col_q} + (DIM_W+1)'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PRE;
      S_PRE: begin
        if (emit_go)              state_d = S_DIV;
        else if (!act_q && pix_ok) state_d = S_WAIT;
        else                      state_d = S_IDLE;
      end
      S_WAIT: state_d = S_DEC;
      S_DEC:  state_d = emit_go ? S_DIV : S_IDLE;
      S_DIV:  if (k_q == '0) state_d = S_BASE;
      S_BASE: state_d = S_NBR;
      S_NBR:  if (dy_q == 2'd2 && dx_q == 2'd2) state_d = S_LAST;
      S_LAST: state_d = S_PUSH;
      S_PUSH: if (push) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      col_q    <= '0;
      row_q    <= '0;
      outcnt_q <= '0;
      wp_q     <= '0;
      act_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid_i) begin
        act_q <= action_i;
      end
      if (state_q == S_PRE && !act_q && pix_ok) begin
        wp_q <= (32'(wp_q) == RING - 1) ? '0 : wp_q + RING_W'(1);
        if (col_inc >= {1'b0, w}) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_inc[COL_W-1:0];
        end
      end
      if (push) begin
        if (fend) begin
          outcnt_q <= '0;
          col_q    <= '0;
          row_q    <= '0;
        end else begin
          outcnt_q <= outcnt_q + CNT_W'(1);
        end
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      pix_q <= {alpha_in_i, blue_in_i, green_in_i, red_in_i};
    end
  end

  // bit-serial row/column split and ring offset reduction
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      pdiv_q <= outcnt_q;
      drem_q <= '0;
      dquo_q <= '0;
      dneg_q <= dval[CNT_W];
      mrem_q <= dval[CNT_W] ? CNT_W'(-dval) : dval[CNT_W-1:0];
      rk_q   <= RK_W'(RING) << (CNT_W - 1);
      k_q    <= K_W'(CNT_W - 1);
    end else if (state_q == S_DIV) begin
      pdiv_q <= pdiv_q << 1;
      if (rem_sh >= {1'b0, w}) begin
        drem_q <= DIM_W'(rem_sh - {1'b0, w});
        dquo_q <= {dquo_q[CNT_W-2:0], 1'b1};
      end else begin
        drem_q <= rem_sh[DIM_W-1:0];
        dquo_q <= {dquo_q[CNT_W-2:0], 1'b0};
      end
      if (RK_W'(mrem_q) >= rk_q) begin
        mrem_q <= CNT_W'(RK_W'(mrem_q) - rk_q);
      end
      rk_q <= rk_q >> 1;
      k_q  <= k_q - K_W'(1);
    end
  end

  always_comb begin
    dm = {1'b0, mrem_q[RING_W-1:0]};
    if (dneg_q && dm != '0) begin
      dm = (RING_W+1)'(RING) - dm;
    end
    base_sum = {1'b0, wp_q} + (RING_W+1)'(RING - 1) - dm;
    if (32'(base_sum) >= RING) begin
      base_sum = base_sum - (RING_W+1)'(RING);
    end
  end

  // neighbor scan
  always_comb begin
    ey = {1'b0, dquo_q} + (CNT_W+1)'(dy_q);
    ex = {1'b0, drem_q} + (DIM_W+1)'(dx_q);
    in_frame = (ey != '0) && (ey <= (CNT_W+1)'(h)) && (ex != '0) && (ex <= {1'b0, w});
    case (dy_q)
      2'd2:    offp = {1'b0, w, 1'b0};
      2'd1:    offp = {2'b00, w};
      default: offp = '0;
    endcase
    offp = offp + (DIM_W+2)'(dx_q);
    addr_sum = (RING_W+3)'(base_q) + (RING_W+3)'(offp) + (RING_W+3)'(RING) -
               (RING_W+3)'(w) - (RING_W+3)'(1);
    if (32'(addr_sum) >= 2 * RING) begin
      addr_sum = addr_sum - (RING_W+3)'(2 * RING);
    end else if (32'(addr_sum) >= RING) begin
      addr_sum = addr_sum - (RING_W+3)'(RING);
    end
    addr = addr_sum[RING_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= (state_q == S_NBR) && in_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PRE && !act_q && pix_ok) begin
      ring_mem[wp_q] <= pix_q;
    end
    if (state_q == S_NBR) begin
      rdata_q <= ring_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ctr_q <= (dy_q == 2'd1) && (dx_q == 2'd1);
    wt_q     <= ((dy_q == 2'd1) && (dx_q == 2'd1)) ? W_CENTER : nw;
    if (state_q == S_BASE) begin
      base_q   <= base_sum[RING_W-1:0];
      dy_q     <= '0;
      dx_q     <= '0;
      acc_q    <= '0;
      ws_q     <= '0;
      center_q <= '0;
    end else begin
      if (state_q == S_NBR) begin
        if (dx_q == 2'd2) begin
          dx_q <= '0;
          dy_q <= dy_q + 2'd1;
        end else begin
          dx_q <= dx_q + 2'd1;
        end
      end
      if (rd_ok_q) begin
        for (int c = 0; c < NCH; c++) begin
          acc_q[c] <= acc_q[c] + ACC_W'(rdata_q[c*CH_W +: CH_W] * wt_q);
        end
        ws_q <= ws_q + WS_W'(wt_q);
        if (rd_ctr_q) begin
          center_q <= rdata_q[PIX_W-1 -: CH_W];
        end
      end
    end
  end

  // divider chain
  always_comb begin
    chain[0].valid = push;
    chain[0].rem   = acc_q;
    chain[0].quo   = '0;
    chain[0].dvs   = ACC_W'((ws_q == '0) ? WS_W'(1) : ws_q) << (QUO_W - 1);
    chain[0].alpha = center_q;
    chain[0].fend  = fend;
    chain_busy = 1'b0;
    for (int i = 1; i <= QUO_W; i++) begin
      chain_busy = chain_busy | chain[i].valid;
    end
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    wdn_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (chain[g]),
      .d_o    (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain[QUO_W].valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain[QUO_W].valid) begin
      out_rgb_q   <= chain[QUO_W].quo;
      out_alpha_q <= chain[QUO_W].alpha;
      out_fend_q  <= chain[QUO_W].fend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_rgb_q[0];
  assign green_out_o = out_rgb_q[1];
  assign blue_out_o  = out_rgb_q[2];
  assign alpha_out_o = out_alpha_q;
  assign frame_end_o = out_fend_q;

endmodule

FILE: src/wdn_checker.sv
// Port-level checks for the denoise filter, bound to the top level.
// Depends on wdn_pkg and weighted_3x3_denoise_filter_assert.svh.
`include "weighted_3x3_denoise_filter_assert.svh"

module wdn_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [wdn_pkg::CH_W-1:0]  red_out_o,
  input logic [wdn_pkg::CH_W-1:0]  green_out_o,
  input logic [wdn_pkg::CH_W-1:0]  blue_out_o,
  input logic [wdn_pkg::CH_W-1:0]  alpha_out_o,
  input logic                      frame_end_o
);

  `WDN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result beat dropped while stalled")
  `WDN_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) && $stable(alpha_out_o) && $stable(frame_end_o), "stalled result changed")
  // one beat at a time: an accepted beat always closes the input
  `WDN_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input open right after accept")
  `WDN_ASSERT_IMP(a_busy_has_cause, clk_i, rst_ni, $rose(in_stall_o), $past(in_valid_i), "input closed without a beat")

endmodule

bind weighted_3x3_denoise_filter wdn_checker u_wdn_checker (.*);
